// File: design/rlqt_pkg.sv
`timescale 1ns / 1ps
package rlqt_pkg;

  localparam int RSS_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int OUT_TDATA_W = 32;

  localparam logic signed [RSS_W-1:0] INVALID_RSS = 8'sd127;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_MID  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS     = 3'd4;

  localparam logic signed [7:0] NOISE_FLOOR_RST    = -8'sd100;
  localparam logic [7:0]        THRESHOLD_LOW_RST  = 8'd2;
  localparam logic [7:0]        THRESHOLD_MID_RST  = 8'd10;
  localparam logic [7:0]        THRESHOLD_HIGH_RST = 8'd20;
  localparam logic [7:0]        HYSTERESIS_RST     = 8'd2;

  typedef struct packed {
    logic accept;
    logic load;
    logic step;
    logic step_last;
    logic cls;
    logic out_load;
  } rlqt_cmd_t;

  typedef struct packed {
    logic sample;
  } rlqt_status_t;

endpackage

// File: design/rlqt_ctrl.sv
`timescale 1ns / 1ps
module rlqt_ctrl #(
  parameter int DIV_W = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  rlqt_pkg::rlqt_status_t status,
  output rlqt_pkg::rlqt_cmd_t   cmd
);
  import rlqt_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_CLS  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;
  logic              out_valid, out_valid_next;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = status.sample ? S_LOAD : S_FIN;
        end
      end
      S_LOAD: begin
        cmd.load      = 1'b1;
        step_cnt_next = '0;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (step_cnt == STEP_LAST) begin
          cmd.step_last = 1'b1;
          state_next    = S_CLS;
        end else begin
          step_cnt_next = step_cnt + 1'b1;
        end
      end
      S_CLS: begin
        cmd.cls    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: design/rlqt_dp.sv
`timescale 1ns / 1ps
module rlqt_dp #(
  parameter int FRACTION_BITS = 3,
  parameter int COUNT_LOG2    = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [rlqt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rlqt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_opcode,
  input  logic signed [rlqt_pkg::RSS_W-1:0]   in_rss,
  input  rlqt_pkg::rlqt_cmd_t                 cmd,
  output rlqt_pkg::rlqt_status_t              status,
  output logic [1:0]                          quality,
  output logic signed [7:0]                   average_rss,
  output logic [6:0]                          link_margin,
  output logic signed [7:0]                   last_rss,
  output logic                                sample_ignored
);
  import rlqt_pkg::*;

  localparam int MEAN_W = 8 + FRACTION_BITS;
  localparam int CNT_W  = COUNT_LOG2 + 1;
  localparam int DIV_W  = MEAN_W + COUNT_LOG2 + 1;
  localparam int PROD_W = MEAN_W + COUNT_LOG2;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(1 << COUNT_LOG2);

  logic signed [7:0] noise_floor;
  logic [7:0]        threshold_low, threshold_mid, threshold_high, hysteresis;

  logic [MEAN_W-1:0] scaled_mean;
  logic [CNT_W-1:0]  sample_count;
  logic [1:0]        quality_level;
  logic signed [7:0] previous_sample;
  logic              have_prev;
  logic              ignored;
  logic [MEAN_W-1:0] new_val;
  logic [DIV_W-1:0]  dvd;
  logic [CNT_W-1:0]  rem;

  logic              is_invalid;
  logic signed [8:0] rss_ext;
  logic [8:0]        rss_neg;
  logic [7:0]        rss_mag;

  logic [PROD_W-1:0]            prod;
  logic [COUNT_LOG2-1:0]        cnt_m1;
  logic [CNT_W:0]               trial;
  logic                         qbit;
  logic [CNT_W-1:0]             rem_next;
  logic [DIV_W-1:0]             dvd_next;

  logic [7:0]        int_part;
  logic signed [9:0] avg10;
  logic signed [9:0] diff10;
  logic [6:0]        margin;
  logic signed [7:0] avg_out;
  logic [8:0]        t1, t2, t3, margin9;
  logic [1:0]        quality_new;

  // input decode
  assign is_invalid    = (in_rss == INVALID_RSS);
  assign status.sample = (in_opcode == OP_ADD) && !is_invalid;
  assign rss_ext       = {in_rss[7], in_rss};
  assign rss_neg       = 9'sd0 - rss_ext;
  assign rss_mag       = in_rss[7] ? rss_neg[7:0] : 8'd0;

  // restoring divide step
  assign cnt_m1   = COUNT_LOG2'(sample_count - 1'b1);
  assign prod     = PROD_W'(scaled_mean) * PROD_W'(cnt_m1);
  assign trial    = {rem, dvd[DIV_W-1]};
  assign qbit     = (trial >= {1'b0, sample_count});
  assign rem_next = qbit ? CNT_W'(trial - {1'b0, sample_count}) : CNT_W'(trial);
  assign dvd_next = {dvd[DIV_W-2:0], qbit};

  // rounded average and margin
  assign int_part = scaled_mean[MEAN_W-1:FRACTION_BITS];
  assign avg10    = 10'sd0 - $signed({2'b00, int_part})
                    - $signed({9'd0, scaled_mean[FRACTION_BITS-1]});
  assign diff10   = avg10 - $signed({{2{noise_floor[7]}}, noise_floor});
  assign avg_out  = (sample_count == '0) ? INVALID_RSS : avg10[7:0];

  always_comb begin
    if (sample_count == '0 || diff10 < 10'sd0) begin
      margin = 7'd0;
    end else if (diff10 > 10'sd127) begin
      margin = 7'd127;
    end else begin
      margin = diff10[6:0];
    end
  end

  // classification with hysteresis above the previous level
  assign t1 = {1'b0, threshold_low}
              + ((have_prev && quality_level == 2'd0) ? {1'b0, hysteresis} : 9'd0);
  assign t2 = {1'b0, threshold_mid}
              + ((have_prev && quality_level <= 2'd1) ? {1'b0, hysteresis} : 9'd0);
  assign t3 = {1'b0, threshold_high}
              + ((have_prev && quality_level <= 2'd2) ? {1'b0, hysteresis} : 9'd0);
  assign margin9 = {2'b00, margin};

  always_comb begin
    if (margin9 > t3) begin
      quality_new = 2'd3;
    end else if (margin9 > t2) begin
      quality_new = 2'd2;
    end else if (margin9 > t1) begin
      quality_new = 2'd1;
    end else begin
      quality_new = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_floor    <= NOISE_FLOOR_RST;
      threshold_low  <= THRESHOLD_LOW_RST;
      threshold_mid  <= THRESHOLD_MID_RST;
      threshold_high <= THRESHOLD_HIGH_RST;
      hysteresis     <= HYSTERESIS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NOISE_FLOOR:    noise_floor    <= $signed(cfg_data);
        REG_THRESHOLD_LOW:  threshold_low  <= cfg_data;
        REG_THRESHOLD_MID:  threshold_mid  <= cfg_data;
        REG_THRESHOLD_HIGH: threshold_high <= cfg_data;
        REG_HYSTERESIS:     hysteresis     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scaled_mean     <= '0;
      sample_count    <= '0;
      quality_level   <= 2'd0;
      previous_sample <= INVALID_RSS;
      have_prev       <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (in_opcode == OP_CLEAR) begin
          scaled_mean     <= '0;
          sample_count    <= '0;
          quality_level   <= 2'd0;
          previous_sample <= INVALID_RSS;
        end else if (!is_invalid) begin
          previous_sample <= in_rss;
          have_prev       <= (sample_count != '0);
          if (sample_count < CNT_MAX) begin
            sample_count <= sample_count + 1'b1;
          end
        end
      end
      if (cmd.step_last) begin
        scaled_mean <= dvd_next[MEAN_W-1:0];
      end
      if (cmd.cls) begin
        quality_level <= quality_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ignored <= (in_opcode == OP_ADD) && is_invalid;
      new_val <= MEAN_W'(rss_mag) << FRACTION_BITS;
    end
    if (cmd.load) begin
      dvd <= DIV_W'(prod) + DIV_W'(new_val);
      rem <= '0;
    end else if (cmd.step) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
    if (cmd.out_load) begin
      quality        <= quality_level;
      average_rss    <= avg_out;
      link_margin    <= margin;
      last_rss       <= previous_sample;
      sample_ignored <= ignored;
    end
  end

endmodule

// File: design/rss_link_quality_tracker.sv
`timescale 1ns / 1ps
// RSS link quality tracker.
// Input beats carry one command: s_tuser = 0 adds the sample in s_tdata
// (signed dBm, 127 = invalid, ignored), s_tuser = 1 clears the tracker.
// Every input beat produces exactly one output beat with link quality,
// rounded average RSS, link margin, last valid RSS and an ignored flag.
// Config writes (cfg_valid/cfg_ready, index + 8-bit data) are always
// accepted; write only while the tracker is idle.
// Processing: a valid sample runs a load step, a bit-serial restoring
// divide of DIV_W = 9 + FRACTION_BITS + COUNT_LOG2 steps for the running
// mean, a classify step and an output step. Clear and invalid samples go
// straight from the accept to the output step. s_tready is high only
// when idle.
// The output register lets a new beat be accepted while a result waits;
// if m_tready stays low the tracker holds its next result and stalls.
// Reset (rst, synchronous) restores the register defaults and empties
// the average: no samples, quality 0, last RSS 127.
module rss_link_quality_tracker #(
  parameter int FRACTION_BITS = 3,
  parameter int COUNT_LOG2    = 3
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [rlqt_pkg::RSS_W-1:0]           s_tdata,  // [7:0] rss
  input  logic                                 s_tuser,  // [0] opcode
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [1:0] quality, [9:2] average_rss, [16:10] link_margin,
  // [24:17] last_rss, [31:25] zero
  output logic [rlqt_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                 m_tuser,  // [0] sample_ignored
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rlqt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rlqt_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rlqt_pkg::*;

  localparam int DIV_W = 8 + FRACTION_BITS + COUNT_LOG2 + 1;

  rlqt_cmd_t         cmd;
  rlqt_status_t      status;
  logic [1:0]        quality;
  logic signed [7:0] average_rss;
  logic [6:0]        link_margin;
  logic signed [7:0] last_rss;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {7'd0, last_rss, link_margin, average_rss, quality};

  rlqt_ctrl #(
    .DIV_W (DIV_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rlqt_dp #(
    .FRACTION_BITS (FRACTION_BITS),
    .COUNT_LOG2    (COUNT_LOG2)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_opcode      (s_tuser),
    .in_rss         ($signed(s_tdata)),
    .cmd            (cmd),
    .status         (status),
    .quality        (quality),
    .average_rss    (average_rss),
    .link_margin    (link_margin),
    .last_rss       (last_rss),
    .sample_ignored (m_tuser)
  );

endmodule

// File: design/rlqt_checker.sv
`timescale 1ns / 1ps
module rlqt_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [rlqt_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input logic                                m_tuser
);
  import rlqt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in process");

  a_margin_needs_avg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[16:10] != 7'd0) |-> (m_tdata[9:2] != 8'h7f))
    else $error("nonzero margin without an average");

  a_empty_quality_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[9:2] == 8'h7f) |-> (m_tdata[1:0] == 2'd0))
    else $error("nonzero quality without an average");

  a_avg_not_positive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[9:2] != 8'h7f) |-> (m_tdata[9] || (m_tdata[9:2] == 8'h00)))
    else $error("positive average reported");

endmodule

bind rss_link_quality_tracker rlqt_checker u_rlqt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
